// ===== rtl/adcv_pkg.sv =====
// adcv_pkg: shared widths, scaling constants, line record type and the
// character lookup for the ADC-to-ASCII voltage block. No dependencies.
`default_nettype none

package adcv_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 4;

  // mv = (sample * 10000 + 1023) / 2046, divided by an exact reciprocal
  localparam int NUM_W    = 24;
  localparam int RECIP_W  = 25;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam int MV_SHIFT = 35;
  localparam int MV_W     = 13;
  localparam logic [NUM_W-1:0]   MV_SCALE = NUM_W'(10000);
  localparam logic [NUM_W-1:0]   MV_BIAS  = NUM_W'(1023);
  localparam logic [RECIP_W-1:0] MV_RECIP =
    RECIP_W'(((64'd1 << MV_SHIFT) + 64'd2045) / 64'd2046);

  localparam logic [MV_W-1:0] UNIT_THOUSANDS = MV_W'(1000);
  localparam logic [MV_W-1:0] UNIT_HUNDREDS  = MV_W'(100);
  localparam logic [MV_W-1:0] UNIT_TENS      = MV_W'(10);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // ASCII characters of the line
  localparam logic [CHAR_W-1:0] CH_O     = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_V     = 8'h56;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  // Character positions within a line
  localparam logic [POS_W-1:0] POS_O      = 4'd0;
  localparam logic [POS_W-1:0] POS_U      = 4'd1;
  localparam logic [POS_W-1:0] POS_T      = 4'd2;
  localparam logic [POS_W-1:0] POS_LABEL  = 4'd3;
  localparam logic [POS_W-1:0] POS_COLON  = 4'd4;
  localparam logic [POS_W-1:0] POS_SPACE  = 4'd5;
  localparam logic [POS_W-1:0] POS_UNITS  = 4'd6;
  localparam logic [POS_W-1:0] POS_DOT    = 4'd7;
  localparam logic [POS_W-1:0] POS_TENTHS = 4'd8;
  localparam logic [POS_W-1:0] POS_HUNDTH = 4'd9;
  localparam logic [POS_W-1:0] POS_THOUTH = 4'd10;
  localparam logic [POS_W-1:0] POS_VOLT   = 4'd11;
  localparam logic [POS_W-1:0] POS_END1   = 4'd12;
  localparam logic [POS_W-1:0] POS_END2   = 4'd13;

  typedef struct packed {
    logic               chan;
    logic [DIGIT_W-1:0] d3;
    logic [DIGIT_W-1:0] d2;
    logic [DIGIT_W-1:0] d1;
    logic [DIGIT_W-1:0] d0;
  } line_rec_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [MV_W-1:0]    rem;
  } digit_split_t;

  // One decimal digit by parallel compares; valid while v < 10 * unit.
  function automatic digit_split_t split_digit(input logic [MV_W-1:0] v,
                                               input logic [MV_W-1:0] unit);
    digit_split_t res;
    logic [MV_W+3:0] thr;
    logic [MV_W+3:0] sub;
    res.digit = '0;
    thr = '0;
    for (int i = 1; i < 10; i++) begin
      thr = (MV_W+4)'(i) * {4'd0, unit};
      if ({4'd0, v} >= thr) begin
        res.digit = DIGIT_W'(i);
      end
    end
    sub = {{MV_W{1'b0}}, res.digit} * {4'd0, unit};
    res.rem = v - sub[MV_W-1:0];
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction

  function automatic logic line_last(input logic chan, input logic [POS_W-1:0] pos);
    return chan ? (pos == POS_END1) : (pos == POS_END2);
  endfunction

  function automatic logic [CHAR_W-1:0] line_char(input line_rec_t rec,
                                                  input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    unique case (pos)
      POS_O:      c = CH_O;
      POS_U:      c = CH_U;
      POS_T:      c = CH_T;
      POS_LABEL:  c = rec.chan ? CH_ONE : CH_TWO;
      POS_COLON:  c = CH_COLON;
      POS_SPACE:  c = CH_SPACE;
      POS_UNITS:  c = digit_char(rec.d3);
      POS_DOT:    c = CH_DOT;
      POS_TENTHS: c = digit_char(rec.d2);
      POS_HUNDTH: c = digit_char(rec.d1);
      POS_THOUTH: c = digit_char(rec.d0);
      POS_VOLT:   c = CH_V;
      POS_END1:   c = rec.chan ? CH_TAB : CH_NL;
      default:    c = CH_NL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/adcv_ifs.sv =====
// Valid/ready channel interfaces of the ADC-to-ASCII voltage block.
// Depends on adcv_pkg for field widths.
`default_nettype none

interface adcv_in_if import adcv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                channel;
  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

interface adcv_out_if import adcv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;
  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/adcv_front.sv =====
// adcv_front: five-stage pipeline that scales a sample to millivolts and
// splits it into decimal digits. Depends on adcv_pkg and adcv_ifs.
`default_nettype none

module adcv_front import adcv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  adcv_in_if.sink    in_ch,
  output line_rec_t  rec,
  output logic       push,
  input  wire logic  q_ready
);

  logic advance;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_chan, s2_chan, s3_chan, s4_chan;
  logic [NUM_W-1:0]   s1_num;
  logic [PROD_W-1:0]  s2_prod;
  logic [DIGIT_W-1:0] s3_d3;
  logic [MV_W-1:0]    s3_rem;
  logic [DIGIT_W-1:0] s4_d3, s4_d2;
  logic [MV_W-1:0]    s4_rem;
  line_rec_t          s5_rec;

  logic [MV_W-1:0] mv;
  digit_split_t    split3, split2, split1;

  // Whole pipe moves together; hold while the last stage cannot unload
  assign advance     = !s5_valid || q_ready;
  assign in_ch.ready = advance;
  assign push        = s5_valid && q_ready;
  assign rec         = s5_rec;

  assign mv     = s2_prod[MV_SHIFT +: MV_W];
  assign split3 = split_digit(mv, UNIT_THOUSANDS);
  assign split2 = split_digit(s3_rem, UNIT_HUNDREDS);
  assign split1 = split_digit(s4_rem, UNIT_TENS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_ch.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_num  <= {{(NUM_W-SAMPLE_W){1'b0}}, in_ch.sample} * MV_SCALE + MV_BIAS;
      s1_chan <= in_ch.channel;
      s2_prod <= {{RECIP_W{1'b0}}, s1_num} * {{NUM_W{1'b0}}, MV_RECIP};
      s2_chan <= s1_chan;
      s3_d3   <= split3.digit;
      s3_rem  <= split3.rem;
      s3_chan <= s2_chan;
      s4_d3   <= s3_d3;
      s4_d2   <= split2.digit;
      s4_rem  <= split2.rem;
      s4_chan <= s3_chan;
      s5_rec.chan <= s4_chan;
      s5_rec.d3   <= s4_d3;
      s5_rec.d2   <= s4_d2;
      s5_rec.d1   <= split1.digit;
      s5_rec.d0   <= split1.rem[DIGIT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adcv_queue.sv =====
// adcv_queue: small FIFO of digit records between front pipeline and
// character sequencer. Depends on adcv_pkg.
`default_nettype none

module adcv_queue import adcv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire line_rec_t  push_rec,
  output logic            can_push,
  input  wire logic       pop,
  output logic            head_valid,
  output line_rec_t       head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  line_rec_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign can_push   = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adcv_back.sv =====
// adcv_back: character sequencer; walks a line record one character per
// beat into a registered output. Depends on adcv_pkg and adcv_ifs.
`default_nettype none

module adcv_back import adcv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire line_rec_t  head,
  output logic            pop,
  adcv_out_if.source      out_ch
);

  logic [POS_W-1:0] pos;
  logic advance;
  logic at_last;

  assign advance = !out_ch.valid || out_ch.ready;
  assign at_last = line_last(head.chan, pos);
  assign pop     = advance && head_valid && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      pos          <= POS_O;
    end else if (advance) begin
      out_ch.valid <= head_valid;
      if (head_valid) begin
        pos <= at_last ? POS_O : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.char_out <= line_char(head, pos);
      out_ch.last     <= at_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adc_to_ascii_voltage.sv =====
// adc_to_ascii_voltage: top level of the ADC sample to ASCII voltage line
// formatter. Depends on adcv_pkg, adcv_ifs, adcv_front, adcv_queue, adcv_back.
//
// Each accepted sample (10-bit code plus channel bit) becomes one text line,
// "Out1: d.dddV<tab>" for channel 1 (13 characters) or "Out2: d.dddV<nl><nl>"
// for channel 0 (14 characters), delivered one character per output beat with
// last set on the final one. The voltage is round-half-up of
// sample * 5000 / 1023 millivolts, computed exactly with a constant
// reciprocal multiply. A five-stage front pipeline does the scaling and digit
// split, a small record queue (QUEUE_DEPTH entries) decouples it from the
// character sequencer, and the sequencer emits one character per cycle while a
// record is waiting and the output is not stalled, with no gap between lines.
// Sustained sample throughput is set by this character output. The input side
// keeps accepting while the queue has room, and the output register lets a
// stalled character wait without blocking the front pipeline.
`default_nettype none

module adc_to_ascii_voltage import adcv_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  adcv_in_if.sink    in_ch,
  adcv_out_if.source out_ch
);

  // Front to queue
  line_rec_t q_rec;
  logic      q_push;
  logic      q_ready;

  // Queue to back
  line_rec_t head;
  logic      head_valid;
  logic      pop;

  adcv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .rec     (q_rec),
    .push    (q_push),
    .q_ready (q_ready)
  );

  adcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (q_rec),
    .can_push   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  adcv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  // A line may only end on a tab or a newline
  a_last_char: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last |-> out_ch.char_out == CH_TAB || out_ch.char_out == CH_NL)
    else $error("line ended on a character other than its terminator");

  // After a line's last beat the next character out starts a new label
  a_new_line: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid || out_ch.char_out == CH_O)
    else $error("line following a last beat did not start with its label");

  // Digits entering the queue stay decimal and within the 5 V range
  a_digits: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_rec.d3 <= 4'd5 && q_rec.d2 <= 4'd9 && q_rec.d1 <= 4'd9 && q_rec.d0 <= 4'd9)
    else $error("digit record out of range");

  // Full scale is exactly 5.000 V
  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    q_push && q_rec.d3 == 4'd5 |-> q_rec.d2 == 4'd0 && q_rec.d1 == 4'd0 && q_rec.d0 == 4'd0)
    else $error("voltage above full scale");

  // Output holds no beat in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for adc_to_ascii_voltage, drives samples and checks
// every character beat of the formatted voltage line against a local predictor.
// Depends on adcv_pkg, adcv_ifs and the adc_to_ascii_voltage RTL.
`default_nettype none

module tb;
  import adcv_pkg::*;

  // Random traffic and run-length knobs
  localparam int RAND_ITEMS = 350;
  localparam int IDLE_PCT   = 18;
  localparam int QUIET_LO   = 150;   // accepted-sample window with no idling
  localparam int QUIET_HI   = 230;
  localparam int PAUSE_AT   = 100;   // hold input here until all lines drain
  localparam int TAIL_CYC   = 20;    // settle time after the last line
  localparam int RUN_LIMIT  = 2000000;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                channel;
  } sample_item_t;

  typedef struct {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } char_beat_t;

  logic clk;
  logic rst;

  adcv_in_if  in_ch ();
  adcv_out_if out_ch ();

  adc_to_ascii_voltage dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_item_t pend_q[$];     // samples waiting to be offered
  char_beat_t   line_q[$];     // characters still owed by the block
  int           accepted_cnt;
  int           err_cnt;

  // Format one sample as the block should: round-half-up millivolts, then
  // "OutN: d.dddV" plus a tab (channel 1) or two newlines (channel 0).
  function automatic void predict_line(input logic [SAMPLE_W-1:0] code,
                                       input logic chan);
    int unsigned       mv;
    logic [CHAR_W-1:0] txt[$];
    mv = (int'(code) * 10000 + 1023) / 2046;
    txt.push_back(CH_O);
    txt.push_back(CH_U);
    txt.push_back(CH_T);
    txt.push_back(chan ? CH_ONE : CH_TWO);
    txt.push_back(CH_COLON);
    txt.push_back(CH_SPACE);
    txt.push_back(CH_ZERO + CHAR_W'((mv / 1000) % 10));
    txt.push_back(CH_DOT);
    txt.push_back(CH_ZERO + CHAR_W'((mv / 100) % 10));
    txt.push_back(CH_ZERO + CHAR_W'((mv / 10) % 10));
    txt.push_back(CH_ZERO + CHAR_W'(mv % 10));
    txt.push_back(CH_V);
    if (chan) begin
      txt.push_back(CH_TAB);
    end else begin
      txt.push_back(CH_NL);
      txt.push_back(CH_NL);
    end
    foreach (txt[i]) begin
      line_q.push_back('{char_out: txt[i], last: (i == txt.size() - 1)});
    end
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] code, input logic chan);
    pend_q.push_back('{sample: code, channel: chan});
  endfunction

  // Clock: 20 time units per cycle
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold reset at the start and give every input a known value from time 0
  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.channel = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Fill the sample queue: a directed opening, then random traffic
  initial begin
    int unsigned pick;
    accepted_cnt = 0;
    err_cnt      = 0;

    // Full-scale extremes on both channels
    add_sample(10'd0,    1'b1);
    add_sample(10'd0,    1'b0);
    add_sample(10'd1023, 1'b1);
    add_sample(10'd1023, 1'b0);
    // One code off each end: smallest nonzero step, just below 5.000 V
    add_sample(10'd1,    1'b1);
    add_sample(10'd1022, 1'b0);
    // Mid scale and rounding near the carry into the next digit
    add_sample(10'd511,  1'b0);
    add_sample(10'd512,  1'b1);
    add_sample(10'd204,  1'b1);
    add_sample(10'd205,  1'b0);
    add_sample(10'd102,  1'b0);
    add_sample(10'd103,  1'b1);
    add_sample(10'd2,    1'b0);
    add_sample(10'd409,  1'b1);
    add_sample(10'd614,  1'b0);
    add_sample(10'd818,  1'b1);
    add_sample(10'd1000, 1'b0);
    // Alternating bit patterns so every sample bit toggles early
    add_sample(10'h155,  1'b1);
    add_sample(10'h2AA,  1'b0);
    add_sample(10'h3FE,  1'b1);
    // Back-to-back lines on the same channel
    add_sample(10'd300,  1'b1);
    add_sample(10'd301,  1'b1);
    add_sample(10'd700,  1'b0);
    add_sample(10'd701,  1'b0);

    // Mostly uniform codes, with a share pushed to the ends of the range
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        add_sample(SAMPLE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        add_sample(SAMPLE_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        add_sample(SAMPLE_W'($urandom_range(1016, 1023)), 1'($urandom_range(0, 1)));
      end
    end
  end

  // Quiet window: neither side idles while these samples go through
  function automatic logic quiet_window();
    return (accepted_cnt >= QUIET_LO) && (accepted_cnt < QUIET_HI);
  endfunction

  // Input driver: retire the accepted beat, then hold, offer the next sample,
  // or idle. Valid gets at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    logic offer_next;
    logic go;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      offer_next = 1'b1;
      if (in_ch.valid) begin
        if (in_ch.ready) begin
          // Beat taken at this edge: predict its line before anything else
          predict_line(in_ch.sample, in_ch.channel);
          void'(pend_q.pop_front());
          accepted_cnt++;
        end else begin
          offer_next = 1'b0;   // hold the beat until it is taken
        end
      end
      if (offer_next) begin
        go = (pend_q.size() != 0);
        // Drain every owed character once, mid-run, before offering more
        if (accepted_cnt == PAUSE_AT && line_q.size() != 0) begin
          go = 1'b0;
        end
        if (go && !quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
          go = 1'b0;
        end
        in_ch.valid <= go;
        if (go) begin
          in_ch.sample  <= pend_q[0].sample;
          in_ch.channel <= pend_q[0].channel;
        end
      end
    end
  end

  // Output monitor: stall ready at random, compare each character beat with
  // the oldest owed character.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_q.size() == 0) begin
          $error("unexpected beat: char_out %h last %b", out_ch.char_out, out_ch.last);
          err_cnt++;
        end else begin
          want = line_q.pop_front();
          if (out_ch.char_out !== want.char_out) begin
            $error("char_out mismatch: expected %h actual %h", want.char_out,
                   out_ch.char_out);
            err_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %b actual %b", want.last, out_ch.last);
            err_cnt++;
          end
        end
      end
      out_ch.ready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // End of run: all samples taken, all characters seen, then a short tail
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    while (pend_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0 && line_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
